FILE: rtl/nmr_pkg.sv
`timescale 1ns / 1ps
// Package for the normal-map renormalizer: widths, payload structs and the
// per-stage records of the pipeline. No dependencies.
package nmr_pkg;

   localparam int CHAN_BITS = 8;
   localparam int FRAC_BITS = 16;

   localparam logic [CHAN_BITS-1:0] CHAN_MAX = {CHAN_BITS{1'b1}};

   // vector component, signed, -CHAN_MAX..CHAN_MAX
   localparam int VW  = CHAN_BITS + 1;
   // one squared component
   localparam int SQW = 2 * CHAN_BITS;
   // squared length, up to 3*CHAN_MAX^2
   localparam int LW  = 2 * CHAN_BITS + 2;
   // reciprocal square root, FRAC_BITS fraction bits (length^2 >= 3 keeps it below 1.0)
   localparam int RW  = FRAC_BITS;
   // running r^2*L, never above 2^(2*FRAC_BITS) once accepted
   localparam int PW  = 2 * FRAC_BITS + 1;
   // running r*L
   localparam int QW  = RW + LW;
   // trial (r + 2^b)^2 * L
   localparam int TW  = 2 * RW + LW + 1;
   // v * r, signed
   localparam int PRW = VW + RW + 1;
   // v * r * CHAN_MAX plus rounding offset
   localparam int NW  = PRW + CHAN_BITS + 1;

   localparam logic [TW-1:0] RS_LIMIT = TW'(1) << (2 * FRAC_BITS);

   typedef struct packed {
      logic [CHAN_BITS-1:0] chan0;
      logic [CHAN_BITS-1:0] chan1;
      logic [CHAN_BITS-1:0] chan2;
      logic [7:0]           alpha_in;
      logic                 last_pixel;
   } req_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] out0;
      logic [CHAN_BITS-1:0] out1;
      logic [CHAN_BITS-1:0] out2;
      logic [7:0]           alpha_out;
      logic                 last_out;
   } rsp_type;

   // values that ride along with an item through the pipeline
   typedef struct packed {
      logic [CHAN_BITS-1:0] c0;
      logic [CHAN_BITS-1:0] c1;
      logic [CHAN_BITS-1:0] c2;
      logic [7:0]           alpha;
      logic                 last;
      logic                 en;
      logic                 zero;
      logic signed [VW-1:0] v0;
      logic signed [VW-1:0] v1;
      logic signed [VW-1:0] v2;
   } side_type;

   // reciprocal square root working set
   typedef struct packed {
      logic [PW-1:0] p;
      logic [QW-1:0] q;
      logic [RW-1:0] r;
      logic [LW-1:0] l;
   } rs_type;

endpackage

FILE: rtl/nmr_rsqrt_stage.sv
`timescale 1ns / 1ps
// One bit of the pipelined reciprocal square root: decides bit BIT_POS of
// r = max r with r^2 * L <= 2^(2*FRAC_BITS). Depends on nmr_pkg.
module nmr_rsqrt_stage
   import nmr_pkg::*;
#(
   parameter int BIT_POS = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  rs_type   in_rs,
   input  side_type in_side,
   output logic     out_valid,
   output rs_type   out_rs,
   output side_type out_side
);

   logic            vld_ff;
   rs_type          rs_ff;
   rs_type          rs_in;
   side_type        side_ff;
   logic [TW-1:0]   trial;
   logic            take;

   // (r + 2^b)^2 L = r^2 L + 2^(b+1) r L + 2^(2b) L
   always_comb begin
      trial = TW'(in_rs.p) + (TW'(in_rs.q) << (BIT_POS + 1))
            + (TW'(in_rs.l) << (2 * BIT_POS));
      take  = (trial <= RS_LIMIT);
      rs_in = in_rs;
      if (take) begin
         rs_in.p = trial[PW-1:0];
         rs_in.q = in_rs.q + (QW'(in_rs.l) << BIT_POS);
         rs_in.r = in_rs.r | (RW'(1) << BIT_POS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rs_ff   <= rs_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = vld_ff;
   assign out_rs    = rs_ff;
   assign out_side  = side_ff;

endmodule

FILE: rtl/normal_map_renormalize.sv
`timescale 1ns / 1ps
// Normal-map renormalizer top level: component setup, squared length, the
// reciprocal square root chain (nmr_rsqrt_stage) and map-back. Uses nmr_pkg.
//
// Usage:
//   req_* carries one RGBA pixel per item (req_valid / req_stall); rsp_*
//   returns the renormalized pixel (rsp_valid / rsp_stall). Every pixel
//   gives exactly one result, in order. csr_* writes normalize_enable
//   (csr_ready is always high); write it only while the block is empty.
//   Throughput: one pixel per clock while req_stall is low. The path to
//   rsp_valid runs through 3 setup stages, one stage per bit of the 16-bit
//   reciprocal square root, 2 map-back stages and the output register.
//   The output register is backed by a one-item skid register, so a pixel
//   is still taken while a result waits; once the skid register fills,
//   req_stall rises and the whole pipeline holds until the result is taken.
//   Reset empties the pipeline and sets normalize_enable to 1.
//   With normalize_enable at 0, or a zero-length vector, color channels are
//   copied. Alpha and the last flag always pass through.
module normal_map_renormalize
   import nmr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_wdata
);

   function automatic logic signed [VW-1:0] to_comp(input logic [CHAN_BITS-1:0] c);
      logic [VW:0] t;
      t = {1'b0, c, 1'b0} - (VW + 1)'(CHAN_MAX);
      return t[VW-1:0];
   endfunction

   function automatic logic [CHAN_BITS-1:0] map_back(input logic signed [PRW-1:0] pr);
      logic signed [NW-1:0] num;
      logic signed [NW-1:0] q;
      logic [CHAN_BITS-1:0] res;
      // v*r*M + M*2^F + 2^F, with M = 2^CHAN_BITS - 1
      num = (NW'(pr) <<< CHAN_BITS) - NW'(pr) + (NW'(1) <<< (FRAC_BITS + CHAN_BITS));
      q   = num >>> (FRAC_BITS + 1);
      if (num < 0) begin
         res = '0;
      end else if (q > NW'(CHAN_MAX)) begin
         res = CHAN_MAX;
      end else begin
         res = q[CHAN_BITS-1:0];
      end
      return res;
   endfunction

   logic                  enable_ff;
   logic                  pipe_en;

   logic                  s1_vld_ff;
   side_type              s1_side_ff;
   logic                  s2_vld_ff;
   side_type              s2_side_ff;
   logic [SQW-1:0]        s2_sq0_ff, s2_sq1_ff, s2_sq2_ff;
   logic signed [2*VW-1:0] m0, m1, m2;
   logic [LW-1:0]         len2;

   logic                  vld_s  [0:RW];
   rs_type                rs_s   [0:RW];
   side_type              side_s [0:RW];
   logic                  s3_vld_ff;
   rs_type                s3_rs_ff;
   side_type              s3_side_ff;
   side_type              s3_side_in;

   logic                  sa_vld_ff;
   side_type              sa_side_ff;
   logic signed [PRW-1:0] sa_pr0_ff, sa_pr1_ff, sa_pr2_ff;
   logic signed [PRW-1:0] r_sgn;

   logic                  sb_vld_ff;
   rsp_type               sb_data_ff;
   rsp_type               sb_data_in;

   logic                  out_vld_ff, out_vld_in;
   rsp_type               out_data_ff, out_data_in;
   logic                  skid_vld_ff, skid_vld_in;
   rsp_type               skid_data_ff, skid_data_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         enable_ff <= csr_wdata;
      end
   end

   // the pipeline moves whenever the skid register is free
   assign pipe_en   = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         sa_vld_ff <= 1'b0;
         sb_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         sa_vld_ff <= vld_s[RW];
         sb_vld_ff <= sa_vld_ff;
      end
   end

   // stage 1: components
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_side_ff.c0    <= req_data.chan0;
         s1_side_ff.c1    <= req_data.chan1;
         s1_side_ff.c2    <= req_data.chan2;
         s1_side_ff.alpha <= req_data.alpha_in;
         s1_side_ff.last  <= req_data.last_pixel;
         s1_side_ff.en    <= enable_ff;
         s1_side_ff.zero  <= 1'b0;
         s1_side_ff.v0    <= to_comp(req_data.chan0);
         s1_side_ff.v1    <= to_comp(req_data.chan1);
         s1_side_ff.v2    <= to_comp(req_data.chan2);
      end
   end

   // stage 2: squares
   always_comb begin
      m0 = s1_side_ff.v0 * s1_side_ff.v0;
      m1 = s1_side_ff.v1 * s1_side_ff.v1;
      m2 = s1_side_ff.v2 * s1_side_ff.v2;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_side_ff <= s1_side_ff;
         s2_sq0_ff  <= m0[SQW-1:0];
         s2_sq1_ff  <= m1[SQW-1:0];
         s2_sq2_ff  <= m2[SQW-1:0];
      end
   end

   // stage 3: squared length, seeds the root chain
   assign len2 = LW'(s2_sq0_ff) + LW'(s2_sq1_ff) + LW'(s2_sq2_ff);

   always_comb begin
      s3_side_in      = s2_side_ff;
      s3_side_in.zero = (len2 == '0);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_rs_ff.p <= '0;
         s3_rs_ff.q <= '0;
         s3_rs_ff.r <= '0;
         s3_rs_ff.l <= len2;
         s3_side_ff <= s3_side_in;
      end
   end

   assign vld_s[0]  = s3_vld_ff;
   assign rs_s[0]   = s3_rs_ff;
   assign side_s[0] = s3_side_ff;

   // one stage per result bit, most significant first
   for (genvar k = 0; k < RW; k++) begin : g_rsqrt
      nmr_rsqrt_stage #(
         .BIT_POS (RW - 1 - k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (pipe_en),
         .in_valid  (vld_s[k]),
         .in_rs     (rs_s[k]),
         .in_side   (side_s[k]),
         .out_valid (vld_s[k+1]),
         .out_rs    (rs_s[k+1]),
         .out_side  (side_s[k+1])
      );
   end

   // stage A: v * r
   assign r_sgn = $signed({{(PRW - RW){1'b0}}, rs_s[RW].r});

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sa_side_ff <= side_s[RW];
         sa_pr0_ff  <= PRW'(side_s[RW].v0) * r_sgn;
         sa_pr1_ff  <= PRW'(side_s[RW].v1) * r_sgn;
         sa_pr2_ff  <= PRW'(side_s[RW].v2) * r_sgn;
      end
   end

   // stage B: scale, round, clamp; copy channels when bypassed
   always_comb begin
      sb_data_in.alpha_out = sa_side_ff.alpha;
      sb_data_in.last_out  = sa_side_ff.last;
      if (!sa_side_ff.en || sa_side_ff.zero) begin
         sb_data_in.out0 = sa_side_ff.c0;
         sb_data_in.out1 = sa_side_ff.c1;
         sb_data_in.out2 = sa_side_ff.c2;
      end else begin
         sb_data_in.out0 = map_back(sa_pr0_ff);
         sb_data_in.out1 = map_back(sa_pr1_ff);
         sb_data_in.out2 = map_back(sa_pr2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sb_data_ff <= sb_data_in;
      end
   end

   // output register plus skid
   always_comb begin
      out_vld_in   = out_vld_ff;
      out_data_in  = out_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (!out_vld_ff || !rsp_stall) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in  = sb_vld_ff;
            out_data_in = sb_data_ff;
         end
      end else if (pipe_en && sb_vld_ff) begin
         skid_vld_in  = 1'b1;
         skid_data_in = sb_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   // a held item in the skid register always has one ahead of it
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid register holds an item with the output register empty");

   // once the waiting result is taken, the skid item moves up and frees the pipe
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff && !rsp_stall |=> out_vld_ff && !skid_vld_ff)
      else $error("skid item not moved to output");

   // odd channel maximum: every component is odd, so the squared length is odd
   a_len_odd: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff |-> s3_rs_ff.l[0])
      else $error("squared length is even");

   // the root chain never accepts a bit that overshoots the limit
   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      vld_s[RW] |-> (TW'(rs_s[RW].p) <= RS_LIMIT))
      else $error("reciprocal square root overshoots");

   // nothing enters while the skid register is full
   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |=> $stable(s1_side_ff) && $stable(s1_vld_ff))
      else $error("pipeline moved while skid register full");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for normal_map_renormalize: a directed table, then random
// pixels under changing idle patterns. Needs nmr_pkg and the block's RTL only.
module testbench
   import nmr_pkg::*;
();

   localparam int HOLD_CYCLES = 80;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                 en;
      logic [CHAN_BITS-1:0] c0;
      logic [CHAN_BITS-1:0] c1;
      logic [CHAN_BITS-1:0] c2;
      logic [7:0]           alpha;
      logic                 last;
      logic                 typed;
      logic [CHAN_BITS-1:0] e0;
      logic [CHAN_BITS-1:0] e1;
      logic [CHAN_BITS-1:0] e2;
      logic [7:0]           ea;
      logic                 el;
   } dir_row_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_wdata = 1'b0;

   rsp_type expected_px[$];
   rsp_type want;
   logic    normalize_on = 1'b1;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_requests = 0;
   int      hold_served   = 0;
   int      hold_cnt      = 0;
   int      error_count   = 0;
   int      results_seen  = 0;
   int      pixels_renorm = 0;
   int      pixels_copied = 0;
   int      input_stalls  = 0;

   // unit axes (these map back onto themselves), extremes, passthrough copies, then more extremes
   dir_row_type directed_rows [18] = '{
      '{1'b1, 8'd255, 8'd127, 8'd127, 8'h11, 1'b0,
        1'b1, 8'd255, 8'd127, 8'd127, 8'h11, 1'b0},
      '{1'b1, 8'd127, 8'd255, 8'd127, 8'h22, 1'b1,
        1'b1, 8'd127, 8'd255, 8'd127, 8'h22, 1'b1},
      '{1'b1, 8'd127, 8'd127, 8'd255, 8'h33, 1'b0,
        1'b1, 8'd127, 8'd127, 8'd255, 8'h33, 1'b0},
      '{1'b1, 8'd0,   8'd127, 8'd127, 8'h00, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0},
      '{1'b1, 8'd127, 8'd0,   8'd127, 8'hFF, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0},
      '{1'b1, 8'd127, 8'd127, 8'd0,   8'h7E, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0},
      '{1'b1, 8'd0,   8'd0,   8'd0,   8'h00, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0},
      '{1'b1, 8'd255, 8'd255, 8'd255, 8'hFF, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0},
      '{1'b1, 8'd127, 8'd127, 8'd127, 8'h01, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0},
      '{1'b1, 8'd128, 8'd128, 8'd128, 8'h80, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0},
      '{1'b1, 8'd128, 8'd0,   8'd255, 8'h3C, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0},
      '{1'b1, 8'd200, 8'd50,  8'd90,  8'hA5, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0},
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'h00, 1'b0,
        1'b1, 8'd0,   8'd0,   8'd0,   8'h00, 1'b0},
      '{1'b0, 8'd255, 8'd255, 8'd255, 8'hFF, 1'b1,
        1'b1, 8'd255, 8'd255, 8'd255, 8'hFF, 1'b1},
      '{1'b0, 8'h55,  8'hAA,  8'h0F,  8'hF0, 1'b1,
        1'b1, 8'h55,  8'hAA,  8'h0F,  8'hF0, 1'b1},
      '{1'b0, 8'd127, 8'd128, 8'd1,   8'h80, 1'b0,
        1'b1, 8'd127, 8'd128, 8'd1,   8'h80, 1'b0},
      '{1'b1, 8'd1,   8'd254, 8'h80,  8'h5A, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0},
      '{1'b1, 8'd255, 8'd0,   8'd255, 8'h01, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0}
   };

   normal_map_renormalize uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("DONE: errors detected");
      $finish;
   end

   // Unit-length rescale of the pixel's normal; colors are copied when disabled
   // or when the squared length is zero (never with an odd channel maximum).
   function automatic rsp_type predict_pixel(req_type px, logic en);
      rsp_type res;
      longint  v [3];
      longint  outc [3];
      longint  len2, limit, r, trial, num, q;
      int      i, b;
      res.out0      = px.chan0;
      res.out1      = px.chan1;
      res.out2      = px.chan2;
      res.alpha_out = px.alpha_in;
      res.last_out  = px.last_pixel;
      v[0] = 2 * longint'(px.chan0) - longint'(CHAN_MAX);
      v[1] = 2 * longint'(px.chan1) - longint'(CHAN_MAX);
      v[2] = 2 * longint'(px.chan2) - longint'(CHAN_MAX);
      len2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      if (en && len2 != 0) begin
         // r = floor(2^16 / sqrt(len2)), built bit by bit from r^2 <= 2^32 / len2
         limit = (longint'(1) << (2 * FRAC_BITS)) / len2;
         r = 0;
         for (b = FRAC_BITS; b >= 0; b--) begin
            trial = r | (longint'(1) << b);
            if (trial * trial <= limit) r = trial;
         end
         for (i = 0; i < 3; i++) begin
            num = v[i] * r * longint'(CHAN_MAX)
                  + longint'(CHAN_MAX) * (longint'(1) << FRAC_BITS)
                  + (longint'(1) << FRAC_BITS);
            if (num < 0) num = 0;
            q = num >>> (FRAC_BITS + 1);
            if (q > longint'(CHAN_MAX)) q = longint'(CHAN_MAX);
            outc[i] = q;
         end
         res.out0 = outc[0][CHAN_BITS-1:0];
         res.out1 = outc[1][CHAN_BITS-1:0];
         res.out2 = outc[2][CHAN_BITS-1:0];
      end
      return res;
   endfunction

   function automatic logic [CHAN_BITS-1:0] random_channel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return CHAN_MAX;
         2: return CHAN_MAX >> 1;
         3: return (CHAN_MAX >> 1) + 1'b1;
         default: return CHAN_BITS'($urandom_range(0, int'(CHAN_MAX)));
      endcase
   endfunction

   function automatic req_type random_pixel();
      req_type px;
      px.chan0      = random_channel();
      px.chan1      = random_channel();
      px.chan2      = random_channel();
      px.alpha_in   = 8'($urandom_range(0, 255));
      px.last_pixel = ($urandom_range(0, 7) == 0);
      return px;
   endfunction

   // offer one item, then keep valid up until the next item or an explicit drop
   task automatic send_pixel(input req_type px, input rsp_type exp);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      expected_px.push_back(exp);
      if (normalize_on) pixels_renorm++;
      else pixels_copied++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
   endtask

   task automatic write_enable(input logic val);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      normalize_on = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_cnt    <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_stall) input_stalls++;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_px.size() == 0) begin
            if (error_count < MAX_REPORTS)
               $display("result %0d arrived with nothing expected: %0d %0d %0d a=%0d last=%0d",
                        results_seen, rsp_data.out0, rsp_data.out1, rsp_data.out2,
                        rsp_data.alpha_out, rsp_data.last_out);
            error_count++;
         end else begin
            want = expected_px.pop_front();
            if (rsp_data.out0 !== want.out0 || rsp_data.out1 !== want.out1 ||
                rsp_data.out2 !== want.out2 || rsp_data.alpha_out !== want.alpha_out ||
                rsp_data.last_out !== want.last_out) begin
               if (error_count < MAX_REPORTS)
                  $display({"result %0d: expected %0d %0d %0d a=%0d last=%0d, ",
                            "got %0d %0d %0d a=%0d last=%0d"},
                           results_seen, want.out0, want.out1, want.out2, want.alpha_out,
                           want.last_out, rsp_data.out0, rsp_data.out1, rsp_data.out2,
                           rsp_data.alpha_out, rsp_data.last_out);
               error_count++;
            end
         end
      end
   end

   initial begin
      req_type px;
      rsp_type exp;
      int      mode, seg;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].en != normalize_on) write_enable(directed_rows[i].en);
         px = '{directed_rows[i].c0, directed_rows[i].c1, directed_rows[i].c2,
                directed_rows[i].alpha, directed_rows[i].last};
         if (directed_rows[i].typed)
            exp = '{directed_rows[i].e0, directed_rows[i].e1, directed_rows[i].e2,
                    directed_rows[i].ea, directed_rows[i].el};
         else
            exp = predict_pixel(px, normalize_on);
         send_pixel(px, exp);
      end

      // slow sender / busy receiver, then the reverse, then full rate
      for (mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 76 : 0;
         recv_idle_pct = (mode == 0) ? 76 : (mode == 1) ? 30 : 0;
         for (seg = 0; seg < 2; seg++) begin
            if ((seg == 0) != normalize_on) write_enable(seg == 0);
            if (mode == 2 && seg == 0) begin
               // long receiver hold-off at full input rate backs the pipeline up
               @(posedge clock);
               hold_requests++;
            end
            repeat ((seg == 0) ? 150 : 32) begin
               px = random_pixel();
               send_pixel(px, predict_pixel(px, normalize_on));
            end
         end
      end

      drain();
      repeat (40) @(posedge clock);
      $display("Sent %0d renormalized and %0d passthrough pixels, checked %0d results.",
               pixels_renorm, pixels_copied, results_seen);
      $display("Input was held off on %0d cycles while the output backed up.", input_stalls);
      if (error_count == 0 && expected_px.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
rtl/nmr_pkg.sv
rtl/nmr_rsqrt_stage.sv
rtl/normal_map_renormalize.sv
sim/testbench.sv
